// ----- src/calendar_date_add_subtract_defines.svh -----
// assertion macros shared by the date shifter rtl
// no dependencies; define ASSERT_OFF to drop every check
`ifndef CALENDAR_DATE_ADD_SUBTRACT_DEFINES_SVH
`define CALENDAR_DATE_ADD_SUBTRACT_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define CDAS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cdas assertion failed");

// expression must never be true outside reset
`define CDAS_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("cdas forbidden condition seen");

`else

`define CDAS_ASSERT(label, clk, rst, prop)
`define CDAS_NEVER(label, clk, rst, expr)

`endif

`endif

// ----- src/cdas_pkg.sv -----
// shared types, constants and calendar helpers for the date shifter
// no dependencies; used by cdas_ctrl, cdas_dpath and the top level
package cdas_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int OFFSET_W = 16;
  localparam int STATUS_W = 2;
  localparam int SUM_W    = OFFSET_W + 1;   // day plus offset
  localparam int R400_W   = 9;              // year mod 400

  localparam int IN_TDATA_W  = ((DAY_W + MONTH_W + YEAR_W + OFFSET_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DAY_W + MONTH_W + YEAR_W + 7) / 8) * 8;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(16383);
  localparam logic [R400_W-1:0]  R400_LAST = R400_W'(399);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAYS_LONG = DAY_W'(31);
  localparam logic [DAY_W-1:0]   DAYS_FEB_LEAP = DAY_W'(29);

  // restoring reduction of the year by 400 << k, k from REM_STEPS-1 down to 0
  localparam int REM_STEPS = 6;
  localparam int REM_CNT_W = 3;
  localparam logic [YEAR_W-1:0] REM_BASE = YEAR_W'(400);

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM,
    S_CHECK,
    S_WALK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                 load;
    logic                 rem_step;
    logic [REM_CNT_W-1:0] rem_shift;
    logic                 check;
    logic                 walk;
    logic                 finish;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic walk_done;
    logic out_free;
  } sts_t;

  // leap from low year bits and year mod 400
  function automatic logic is_leap(input logic [1:0] ylo, input logic [R400_W-1:0] r400);
    return (ylo == 2'd0) && !(r400 inside {R400_W'(100), R400_W'(200), R400_W'(300)});
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - MONTH_JAN;
    if (m == '0 || m > MONTH_DEC) begin
      return DAYS_LONG;
    end else if (m == MONTH_FEB && leap) begin
      return DAYS_FEB_LEAP;
    end else begin
      return MONTH_LEN[idx];
    end
  endfunction

  function automatic logic [YEAR_W-1:0] rem_div(input logic [REM_CNT_W-1:0] k);
    return REM_BASE << k;
  endfunction

endpackage

// ----- src/cdas_ctrl.sv -----
// sequencer for the date shifter: accept, year reduction, check, month walk, finish
// depends on cdas_pkg
module cdas_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cdas_pkg::sts_t sts,
  output cdas_pkg::cmd_t cmd
);
  import cdas_pkg::*;

  state_t               state, state_next;
  logic [REM_CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_REM;
          cnt_next   = REM_CNT_W'(REM_STEPS - 1);
        end
      end
      S_REM: begin
        if (cnt == '0) begin
          state_next = S_CHECK;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_CHECK: begin
        state_next = sts.invalid ? S_FINISH : S_WALK;
      end
      S_WALK: begin
        if (sts.walk_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    cmd.rem_shift = cnt;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_REM:    cmd.rem_step = 1'b1;
      S_CHECK:  cmd.check    = 1'b1;
      S_WALK:   cmd.walk     = !sts.walk_done;
      S_FINISH: cmd.finish   = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ----- src/cdas_dpath.sv -----
// datapath of the date shifter: year mod 400, date check, month walk, result register
// depends on cdas_pkg and calendar_date_add_subtract_defines.svh
`include "calendar_date_add_subtract_defines.svh"

module cdas_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  cdas_pkg::cmd_t                 cmd,
  output cdas_pkg::sts_t                 sts,
  input  logic                           command,
  input  logic [cdas_pkg::DAY_W-1:0]     day_in,
  input  logic [cdas_pkg::MONTH_W-1:0]   month_in,
  input  logic [cdas_pkg::YEAR_W-1:0]    year_in,
  input  logic [cdas_pkg::OFFSET_W-1:0]  offset,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cdas_pkg::DAY_W-1:0]     day_out,
  output logic [cdas_pkg::MONTH_W-1:0]   month_out,
  output logic [cdas_pkg::YEAR_W-1:0]    year_out,
  output logic [cdas_pkg::STATUS_W-1:0]  status
);
  import cdas_pkg::*;

  logic                cmd_sub;
  logic [DAY_W-1:0]    d0;
  logic [MONTH_W-1:0]  m0;
  logic [YEAR_W-1:0]   y0;
  logic [OFFSET_W-1:0] off;
  logic [YEAR_W-1:0]   r;       // remainder during reduction, then year mod 400
  logic [SUM_W-1:0]    d;
  logic [OFFSET_W-1:0] left;
  logic [MONTH_W-1:0]  m;
  logic [YEAR_W-1:0]   y;
  stat_t               st;

  logic [YEAR_W-1:0]   div;
  logic                leap0, leap_cur, invalid;
  logic [DAY_W-1:0]    dim0, dim_cur, dim_prev;
  logic [R400_W-1:0]   r400;

  assign r400     = r[R400_W-1:0];
  assign div      = rem_div(cmd.rem_shift);
  assign leap0    = is_leap(y0[1:0], r400);
  assign dim0     = month_days(m0, leap0);
  assign invalid  = (m0 == '0) || (m0 > MONTH_DEC) || (d0 == '0) || (d0 > dim0);
  assign leap_cur = is_leap(y[1:0], r400);
  assign dim_cur  = month_days(m, leap_cur);
  assign dim_prev = month_days(m - MONTH_JAN, leap_cur);

  assign sts.invalid   = invalid;
  assign sts.walk_done = (st != ST_OK) ||
                         (cmd_sub ? (left == '0) : (d <= SUM_W'(dim_cur)));
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_sub <= command;
      d0      <= day_in;
      m0      <= month_in;
      y0      <= year_in;
      off     <= offset;
      r       <= year_in;
      st      <= ST_OK;
    end

    if (cmd.rem_step && r >= div) begin
      r <= r - div;
    end

    if (cmd.check) begin
      m    <= m0;
      y    <= y0;
      left <= off;
      d    <= cmd_sub ? SUM_W'(d0) : SUM_W'(d0) + SUM_W'(off);
      if (invalid) begin
        st <= ST_INVALID;
      end
    end

    if (cmd.walk) begin
      if (!cmd_sub) begin
        // carry one whole month forward
        d <= d - SUM_W'(dim_cur);
        if (m == MONTH_DEC) begin
          if (y == YEAR_MAX) begin
            st <= ST_RANGE;
          end else begin
            m <= MONTH_JAN;
            y <= y + 1'b1;
            r <= (r400 == R400_LAST) ? '0 : r + 1'b1;
          end
        end else begin
          m <= m + 1'b1;
        end
      end else if (d > SUM_W'(left)) begin
        d    <= d - SUM_W'(left);
        left <= '0;
      end else begin
        // borrow the previous month
        left <= left - OFFSET_W'(d);
        if (m == MONTH_JAN) begin
          if (y == '0) begin
            st <= ST_RANGE;
          end else begin
            m <= MONTH_DEC;
            y <= y - 1'b1;
            r <= (r400 == '0) ? YEAR_W'(R400_LAST) : r - 1'b1;
            d <= SUM_W'(DAYS_LONG);
          end
        end else begin
          m <= m - 1'b1;
          d <= SUM_W'(dim_prev);
        end
      end
    end

    if (cmd.finish) begin
      status <= st;
      if (st != ST_OK) begin
        day_out   <= d0;
        month_out <= m0;
        year_out  <= y0;
      end else begin
        day_out   <= d[DAY_W-1:0];
        month_out <= m;
        year_out  <= y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `CDAS_ASSERT(a_walk_month_range, clk, rst, cmd.walk |-> (m >= MONTH_JAN && m <= MONTH_DEC))
  `CDAS_ASSERT(a_walk_r400_tracks_year, clk, rst, cmd.walk |-> (r[1:0] == y[1:0] && r < 400))
  `CDAS_ASSERT(a_add_step_needed, clk, rst, (cmd.walk && !cmd_sub) |-> (d > SUM_W'(dim_cur)))
  `CDAS_NEVER(a_finish_overwrite, clk, rst, cmd.finish && out_valid && !out_ready)

endmodule

// ----- src/calendar_date_add_subtract.sv -----
// top level of the gregorian date shifter (add or subtract a day count)
// depends on cdas_pkg, cdas_ctrl and cdas_dpath
//
// channel  dir  handshake                       payload
// s_axis   in   s_axis_tvalid / s_axis_tready   tdata: day, month, year, offset; tuser: command
// m_axis   out  m_axis_tvalid / m_axis_tready   tdata: day, month, year; tuser: status
//
// one item at a time; the month walk steps through each month boundary crossed
// the year mod 400 needed for leap years takes six restoring steps before the check
// the result waits in an output register, so a new item is taken while it is stalled
// rst is synchronous, active high, and clears the sequencer and m_axis_tvalid
module calendar_date_add_subtract (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // day_in [4:0], month_in [8:5], year_in [22:9], offset [38:23], zero [39]
  input  logic [cdas_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // command [0]: 0 add, 1 subtract
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // day_out [4:0], month_out [8:5], year_out [22:9], zero [23]
  output logic [cdas_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // status [1:0]: 0 ok, 1 invalid input date, 2 year out of range
  output logic [cdas_pkg::STATUS_W-1:0]      m_axis_tuser
);
  import cdas_pkg::*;

  localparam int MON_LO = DAY_W;
  localparam int YR_LO  = DAY_W + MONTH_W;
  localparam int OFF_LO = DAY_W + MONTH_W + YEAR_W;
  localparam int OUT_PAD = OUT_TDATA_W - YR_LO - YEAR_W;

  cmd_t cmd;
  sts_t sts;

  logic [DAY_W-1:0]   day_out;
  logic [MONTH_W-1:0] month_out;
  logic [YEAR_W-1:0]  year_out;

  // sequencer
  cdas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // field unpacking happens at the port; the datapath captures on load
  cdas_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .command   (s_axis_tuser[0]),
    .day_in    (s_axis_tdata[MON_LO-1:0]),
    .month_in  (s_axis_tdata[YR_LO-1:MON_LO]),
    .year_in   (s_axis_tdata[OFF_LO-1:YR_LO]),
    .offset    (s_axis_tdata[OFF_LO+OFFSET_W-1:OFF_LO]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .day_out   (day_out),
    .month_out (month_out),
    .year_out  (year_out),
    .status    (m_axis_tuser)
  );

  // result packing, zero fill to a whole byte
  assign m_axis_tdata = {{OUT_PAD{1'b0}}, year_out, month_out, day_out};

endmodule
